// ===== rtl/gvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gvp_pkg;

    localparam int GRID_MAX_DEF     = 1024;
    localparam int TRIG_ENTRIES_DEF = 1024;

    localparam int COL_W    = 10;
    localparam int HEIGHT_W = 16;
    localparam int COLOR_W  = 24;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int ANGLE_W = 12;
    localparam int ZOOM_W  = 16;
    localparam int SHIFT_W = 16;
    localparam int COUNT_W = 11;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_X = 4'd0,
        CFG_ANGLE_Y = 4'd1,
        CFG_ANGLE_Z = 4'd2,
        CFG_ZOOM    = 4'd3,
        CFG_SHIFT_X = 4'd4,
        CFG_SHIFT_Y = 4'd5,
        CFG_COLUMNS = 4'd6,
        CFG_ROWS    = 4'd7
    } t_cfg_idx;

    // Restoring long division, used only while the sine table is built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [16:0] quarter_sine(input longint unsigned k,
                                                 input longint unsigned entries);
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        th   = div_u64(PI_HALF_Q30 * k, entries);
        th2  = (th * th) >> 30;
        term = th;
        sum  = longint'(th);
        for (int n = 1; n <= 12; n++) begin
            term = div_u64((term * th2) >> 30, longint'((2 * n) * (2 * n + 1)));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return 17'(r);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gvp_point_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gvp_point_if
    import gvp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [COL_W-1:0]           column;
    logic [COL_W-1:0]           row;
    logic signed [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]         point_color;

    modport source (output valid, column, row, height, point_color, input ready);
    modport sink   (input valid, column, row, height, point_color, output ready);
endinterface

`default_nettype wire

// ===== rtl/gvp_vertex_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gvp_vertex_if
    import gvp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic signed [OUT_W-1:0] depth;
    logic [COLOR_W-1:0]      out_color;

    modport source (output valid, screen_x, screen_y, depth, out_color, input ready);
    modport sink   (input valid, screen_x, screen_y, depth, out_color, output ready);
endinterface

`default_nettype wire

// ===== rtl/gvp_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gvp_cfg_if
    import gvp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/grid_vertex_projection.sv =====
// An accepted request passes through the registered stages r0 to r8; r8 is the output register.
// One vertex is accepted per cycle while no refresh runs; a stall on the output freezes
// the whole pipeline. After reset and after every configuration write, the sine/cosine
// refresh steps through the quarter-wave ROM port, and no vertex is accepted meanwhile.
// Reset is synchronous and active low; only the config and control registers are reset.
`timescale 1ns / 1ps
`default_nettype none

module grid_vertex_projection
    import gvp_pkg::*;
#(
    parameter int GRID_MAX     = GRID_MAX_DEF,
    parameter int TRIG_ENTRIES = TRIG_ENTRIES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gvp_cfg_if.sink     i_cfg,
    gvp_point_if.sink   i_point,
    gvp_vertex_if.source o_vertex
);

    localparam int IW     = $clog2(TRIG_ENTRIES + 1);
    localparam int MW     = 10 + IW;
    localparam int TW     = 18;
    localparam int CW     = 13;
    localparam int PXW    = CW + 17;
    localparam int PZW    = 34;
    localparam int P1W    = PZW + TW;
    localparam int V1W    = 36;
    localparam int P2W    = V1W + TW;
    localparam int V2W    = 37;
    localparam int P3W    = V2W + TW;
    localparam int V3W    = 38;
    localparam int FW     = 39;
    localparam int NSTAGE = 9;
    localparam logic [2:0] TRIG_LAST = 3'd6;

    typedef logic [16:0] t_rom [TRIG_ENTRIES+1];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= TRIG_ENTRIES; k++) begin
            rom[k] = quarter_sine(longint'(k), longint'(TRIG_ENTRIES));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    function automatic logic [OUT_W-1:0] finish(input logic signed [FW-1:0] v);
        logic signed [FW-1:0] t;
        logic signed [FW-1:0] q;
        t = v[FW-1] ? v + FW'(511) : v;
        q = t >>> 9;
        if (q > FW'(signed'(24'sh7FFFFF))) begin
            return 24'h7FFFFF;
        end else if (q < FW'(signed'(-25'sd8388608))) begin
            return 24'h800000;
        end
        return q[OUT_W-1:0];
    endfunction

    logic [ANGLE_W-1:0]        r_angle_x, r_angle_y, r_angle_z;
    logic [ZOOM_W-1:0]         r_zoom;
    logic signed [SHIFT_W-1:0] r_shift_x, r_shift_y;
    logic [COUNT_W-1:0]        r_columns, r_rows;

    logic              r_busy;
    logic [2:0]        r_step;
    logic [16:0]       r_rom_q;
    logic              r_neg;
    logic signed [TW-1:0] r_trig [6];

    logic [ANGLE_W-1:0] n_angle;
    logic [ANGLE_W-1:0] n_ang_sum;
    logic [MW-1:0]      n_prod;
    logic [IW-1:0]      n_idx;
    logic [IW-1:0]      n_addr;

    logic              w_cfg_wr;
    logic              w_en;
    logic              w_acc;
    logic [NSTAGE-1:0] r_vld;

    logic [COL_W-1:0]   n_col, n_row;
    logic [COUNT_W-1:0] n_gc, n_gr;

    logic signed [CW-1:0]       r0_cx, r0_cy;
    logic signed [HEIGHT_W-1:0] r0_h;
    logic signed [PXW-1:0]      r1_px, r1_py;
    logic signed [PZW-1:0]      r1_pz;
    logic signed [P1W-1:0]      r2_p [4];
    logic signed [PXW-1:0]      r2_px;
    logic signed [V1W-1:0]      r3_y1, r3_z1;
    logic signed [PXW-1:0]      r3_px;
    logic signed [P2W-1:0]      r4_p [4];
    logic signed [V1W-1:0]      r4_y1;
    logic signed [V2W-1:0]      r5_z2, r5_x1;
    logic signed [V1W-1:0]      r5_y1;
    logic signed [P3W-1:0]      r6_p [4];
    logic signed [V2W-1:0]      r6_z2;
    logic signed [FW-1:0]       r7_x, r7_y, r7_z;
    logic [COLOR_W-1:0]         r_color [NSTAGE];
    logic [OUT_W-1:0]           r8_x, r8_y, r8_z;

    assign w_cfg_wr = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_x <= '0;
            r_angle_y <= '0;
            r_angle_z <= '0;
            r_zoom    <= ZOOM_W'(256);
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_columns <= COUNT_W'(1);
            r_rows    <= COUNT_W'(1);
        end else if (w_cfg_wr) begin
            unique case (i_cfg.index)
                CFG_ANGLE_X: r_angle_x <= i_cfg.data[ANGLE_W-1:0];
                CFG_ANGLE_Y: r_angle_y <= i_cfg.data[ANGLE_W-1:0];
                CFG_ANGLE_Z: r_angle_z <= i_cfg.data[ANGLE_W-1:0];
                CFG_ZOOM:    r_zoom    <= i_cfg.data;
                CFG_SHIFT_X: r_shift_x <= signed'(i_cfg.data);
                CFG_SHIFT_Y: r_shift_y <= signed'(i_cfg.data);
                CFG_COLUMNS: r_columns <= i_cfg.data[COUNT_W-1:0];
                CFG_ROWS:    r_rows    <= i_cfg.data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_step[2:1])
            2'd0:    n_angle = r_angle_x;
            2'd1:    n_angle = r_angle_y;
            default: n_angle = r_angle_z;
        endcase
        n_ang_sum = r_step[0] ? n_angle : n_angle + ANGLE_W'(1024);
        n_prod    = {{(MW-10){1'b0}}, n_ang_sum[9:0]} * MW'(TRIG_ENTRIES);
        n_idx     = n_prod[MW-1:10];
        n_addr    = n_ang_sum[10] ? IW'(TRIG_ENTRIES) - n_idx : n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (w_cfg_wr) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == TRIG_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_ROM[n_addr];
        r_neg   <= n_ang_sum[11];
        if (r_busy && r_step != 3'd0) begin
            r_trig[r_step - 3'd1] <= r_neg ? -signed'({1'b0, r_rom_q})
                                           :  signed'({1'b0, r_rom_q});
        end
    end

    assign w_en          = !o_vertex.valid || o_vertex.ready;
    assign i_point.ready = w_en && !r_busy;
    assign w_acc         = i_point.valid && i_point.ready;

    always_comb begin
        n_col = (int'(i_point.column) >= GRID_MAX) ? COL_W'(GRID_MAX - 1) : i_point.column;
        n_row = (int'(i_point.row) >= GRID_MAX) ? COL_W'(GRID_MAX - 1) : i_point.row;
        n_gc  = (int'(r_columns) > GRID_MAX) ? COUNT_W'(GRID_MAX) : r_columns;
        n_gr  = (int'(r_rows) > GRID_MAX) ? COUNT_W'(GRID_MAX) : r_rows;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_cx <= signed'({2'b00, n_col, 1'b0}) - signed'({2'b00, n_gc});
            r0_cy <= signed'({2'b00, n_row, 1'b0}) - signed'({2'b00, n_gr});
            r0_h  <= i_point.height;
            r_color[0] <= i_point.point_color;
            for (int s = 1; s < NSTAGE; s++) begin
                r_color[s] <= r_color[s-1];
            end

            r1_px <= PXW'(r0_cx * signed'({1'b0, r_zoom}));
            r1_py <= PXW'(r0_cy * signed'({1'b0, r_zoom}));
            r1_pz <= PZW'(signed'({r0_h, 1'b0}) * signed'({1'b0, r_zoom}));

            r2_p[0] <= P1W'(r1_py * r_trig[0]);
            r2_p[1] <= P1W'(r1_pz * r_trig[1]);
            r2_p[2] <= P1W'(r1_py * r_trig[1]);
            r2_p[3] <= P1W'(r1_pz * r_trig[0]);
            r2_px   <= r1_px;

            r3_y1 <= V1W'((r2_p[0] - r2_p[1]) >>> 15);
            r3_z1 <= V1W'((r2_p[2] + r2_p[3]) >>> 15);
            r3_px <= r2_px;

            r4_p[0] <= P2W'(r3_z1 * r_trig[2]);
            r4_p[1] <= P2W'(r3_px * r_trig[3]);
            r4_p[2] <= P2W'(r3_px * r_trig[2]);
            r4_p[3] <= P2W'(r3_z1 * r_trig[3]);
            r4_y1   <= r3_y1;

            r5_z2 <= V2W'((r4_p[0] - r4_p[1]) >>> 15);
            r5_x1 <= V2W'((r4_p[2] + r4_p[3]) >>> 15);
            r5_y1 <= r4_y1;

            r6_p[0] <= P3W'(r5_x1 * r_trig[4]);
            r6_p[1] <= P3W'(r5_y1 * r_trig[5]);
            r6_p[2] <= P3W'(r5_y1 * r_trig[4]);
            r6_p[3] <= P3W'(r5_x1 * r_trig[5]);
            r6_z2   <= r5_z2;

            r7_x <= FW'(V3W'((r6_p[0] - r6_p[1]) >>> 15)) + FW'(signed'({r_shift_x, 9'd0}));
            r7_y <= FW'(V3W'((r6_p[2] + r6_p[3]) >>> 15)) + FW'(signed'({r_shift_y, 9'd0}));
            r7_z <= FW'(r6_z2);

            r8_x <= finish(r7_x);
            r8_y <= finish(r7_y);
            r8_z <= finish(r7_z);
        end
    end

    assign o_vertex.valid     = r_vld[NSTAGE-1];
    assign o_vertex.screen_x  = signed'(r8_x);
    assign o_vertex.screen_y  = signed'(r8_y);
    assign o_vertex.depth     = signed'(r8_z);
    assign o_vertex.out_color = r_color[NSTAGE-1];

    a_cfg_starts_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> r_busy && !i_point.ready)
        else $error("configuration write did not start the trig refresh");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= TRIG_LAST)
        else $error("trig refresh step out of range");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

endmodule

`default_nettype wire
